[rtl/ltpe_pkg.sv]
// LED triangle pose estimate: shared package.
// Holds register indexes, select codes, heading constants, the CORDIC angle table
// and the queue status struct. Depends on nothing.
`timescale 1ns / 1ps

package ltpe_pkg;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int ANG_TAB_LEN = 24;
    localparam int ANG_W       = 25;
    localparam int OFS_W       = 22;
    localparam int HEAD_W      = 16;
    localparam int HEAD_OUT_W  = 15;

    localparam logic [OFS_W-1:0]  OFS_MAX      = 22'h1F_FFFF;
    localparam logic [HEAD_W-1:0] HEAD_QUARTER = 16'd5760;
    localparam logic [HEAD_W-1:0] HEAD_HALF    = 16'd11520;
    localparam logic [HEAD_W-1:0] HEAD_FULL    = 16'd23040;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LENGTH  = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_MARKER_SELECT = 2'd2
    } reg_idx_t;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // atan(2^-i) in degrees * 65536
    function automatic logic signed [ANG_W-1:0] ang_tab(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/led_triangle_pose_estimate_top.sv]
// LED triangle pose estimate: top level with configuration registers.
// Instantiates ltpe_front, ltpe_queue and ltpe_back; depends on ltpe_pkg.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   input    | s_valid / s_ready  | s_a_x s_a_y s_b_x s_b_y s_c_x s_c_y s_heading_flip
//   result   | m_valid / m_ready  | m_offset_x m_offset_y m_heading m_sign_undefined
//   config   | cfg_we             | cfg_index cfg_data
//
// The front takes a request every cycle, while not stalled by a full two-entry queue.
// The back takes one request at a time, paced by the one-bit-a-cycle square
// root (31 steps), the two parallel dividers (23 steps) and the normalize shifter.
// The heading CORDIC runs alongside and is never the long path.
// The back starts the next request while a result waits in the output register.
// Synchronous active-low reset clears control state and loads 640, 480 and 0.
`timescale 1ns / 1ps

module led_triangle_pose_estimate_top
    import ltpe_pkg::*;
#(
    parameter int COORD_BITS    = 12,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [COORD_BITS-1:0]        s_a_x,
    input  logic [COORD_BITS-1:0]        s_a_y,
    input  logic [COORD_BITS-1:0]        s_b_x,
    input  logic [COORD_BITS-1:0]        s_b_y,
    input  logic [COORD_BITS-1:0]        s_c_x,
    input  logic [COORD_BITS-1:0]        s_c_y,
    input  logic                         s_heading_flip,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [OFS_W-1:0]      m_offset_x,
    output logic signed [OFS_W-1:0]      m_offset_y,
    output logic [HEAD_OUT_W-1:0]        m_heading,
    output logic                         m_sign_undefined,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data
);

    localparam int MW = COORD_BITS + 3;
    localparam int DW = (COORD_BITS > 12 ? COORD_BITS : 12) + 3;
    localparam int EW = 2*MW + 2*DW + 2;

    logic [CFG_W-1:0] frame_length_reg, frame_height_reg;
    logic [1:0]       marker_select_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg  <= 13'd640;
            frame_height_reg  <= 13'd480;
            marker_select_reg <= 2'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_LENGTH:  frame_length_reg  <= cfg_data;
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                REG_MARKER_SELECT: marker_select_reg <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    q_stat_t       q_stat;
    logic          push_valid, pop;
    logic [EW-1:0] push_data, head_data;

    ltpe_front #(
        .CB(COORD_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_a_x         (s_a_x),
        .s_a_y         (s_a_y),
        .s_b_x         (s_b_x),
        .s_b_y         (s_b_y),
        .s_c_x         (s_c_x),
        .s_c_y         (s_c_y),
        .s_heading_flip(s_heading_flip),
        .frame_length  (frame_length_reg),
        .frame_height  (frame_height_reg),
        .marker_select (marker_select_reg),
        .q_stat        (q_stat),
        .push_valid    (push_valid),
        .push_data     (push_data)
    );

    ltpe_queue #(
        .W(EW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_stat    (q_stat)
    );

    ltpe_back #(
        .CB    (COORD_BITS),
        .STAGES(CORDIC_STAGES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_stat          (q_stat),
        .head_data       (head_data),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_offset_x      (m_offset_x),
        .m_offset_y      (m_offset_y),
        .m_heading       (m_heading),
        .m_sign_undefined(m_sign_undefined)
    );

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sign_undefined) |-> (m_offset_x == '0 && m_offset_y == '0))
        else $error("offsets not zero with sign undefined");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (15'(m_heading) <= 15'(HEAD_FULL)))
        else $error("heading out of range");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_stat.full)
        else $error("input stalled with room in queue");

    a_queue_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

endmodule

[rtl/ltpe_front.sv]
// LED triangle pose estimate: front stage.
// Accepts a point triple, forms centroid and marker offsets in thirds of a pixel.
// Depends on ltpe_pkg.
`timescale 1ns / 1ps

module ltpe_front
    import ltpe_pkg::*;
#(
    parameter int CB = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CB-1:0]             s_a_x,
    input  logic [CB-1:0]             s_a_y,
    input  logic [CB-1:0]             s_b_x,
    input  logic [CB-1:0]             s_b_y,
    input  logic [CB-1:0]             s_c_x,
    input  logic [CB-1:0]             s_c_y,
    input  logic                      s_heading_flip,
    input  logic [CFG_W-1:0]          frame_length,
    input  logic [CFG_W-1:0]          frame_height,
    input  logic [1:0]                marker_select,
    input  q_stat_t                   q_stat,
    output logic                      push_valid,
    output logic [2*(CB+3)+2*((CB > 12 ? CB : 12)+3)+1:0] push_data
);

    localparam int MW = CB + 3;
    localparam int DW = (CB > 12 ? CB : 12) + 3;
    localparam int EW = 2*MW + 2*DW + 2;

    logic [CB+1:0]          sx, sy, px3, py3;
    logic [CB-1:0]          px, py;
    logic [13:0]            cx3, cy3;
    logic signed [MW-1:0]   mx, my;
    logic signed [DW-1:0]   dx3, dy3;
    logic [EW-1:0]          entry;
    logic                   accept;

    logic                   f_valid_reg, f_valid_next;
    logic [EW-1:0]          f_data_reg;

    always_comb begin
        case (marker_select)
            SEL_A: begin
                px = s_a_x;
                py = s_a_y;
            end
            SEL_B: begin
                px = s_b_x;
                py = s_b_y;
            end
            default: begin
                px = s_c_x;
                py = s_c_y;
            end
        endcase
    end

    assign sx  = (CB+2)'(s_a_x) + (CB+2)'(s_b_x) + (CB+2)'(s_c_x);
    assign sy  = (CB+2)'(s_a_y) + (CB+2)'(s_b_y) + (CB+2)'(s_c_y);
    assign px3 = (CB+2)'(px) + (CB+2)'({px, 1'b0});
    assign py3 = (CB+2)'(py) + (CB+2)'({py, 1'b0});
    assign cx3 = 14'(frame_length[CFG_W-1:1]) + 14'({frame_length[CFG_W-1:1], 1'b0});
    assign cy3 = 14'(frame_height[CFG_W-1:1]) + 14'({frame_height[CFG_W-1:1], 1'b0});

    assign mx  = $signed({1'b0, sx}) - $signed({1'b0, px3});
    assign my  = $signed({1'b0, sy}) - $signed({1'b0, py3});
    assign dx3 = $signed(DW'(sx)) - $signed(DW'(cx3));
    assign dy3 = $signed(DW'(sy)) - $signed(DW'(cy3));

    assign entry = {s_heading_flip, (dy3 == '0), mx, my, dx3, dy3};

    assign s_ready    = !f_valid_reg || !q_stat.full;
    assign accept     = s_valid && s_ready;
    assign push_valid = f_valid_reg && !q_stat.full;
    assign push_data  = f_data_reg;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (push_valid) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f_data_reg <= entry;
        end
    end

endmodule

[rtl/ltpe_queue.sv]
// LED triangle pose estimate: two-entry request queue between front and back.
// Depends on ltpe_pkg for the status struct.
`timescale 1ns / 1ps

module ltpe_queue
    import ltpe_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head_data,
    output q_stat_t      q_stat
);

    logic [1:0]   count_reg, count_next;
    logic [W-1:0] slot0_reg, slot1_reg;

    assign head_data    = slot0_reg;
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    always_comb begin
        count_next = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push_valid) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (push_valid && count_reg == 2'd1) begin
                slot0_reg <= push_data;
            end else begin
                slot0_reg <= slot1_reg;
            end
            if (push_valid && count_reg == 2'd2) begin
                slot1_reg <= push_data;
            end
        end else if (push_valid) begin
            if (count_reg == 2'd0) begin
                slot0_reg <= push_data;
            end else begin
                slot1_reg <= push_data;
            end
        end
    end

endmodule

[rtl/ltpe_back.sv]
// LED triangle pose estimate: back end.
// Runs the heading CORDIC and the offset sequencer (products, normalize, square
// root, division) and holds the result register. Depends on ltpe_pkg.
`timescale 1ns / 1ps

module ltpe_back
    import ltpe_pkg::*;
#(
    parameter int CB     = 12,
    parameter int STAGES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  q_stat_t                     q_stat,
    input  logic [2*(CB+3)+2*((CB > 12 ? CB : 12)+3)+1:0] head_data,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OFS_W-1:0]     m_offset_x,
    output logic signed [OFS_W-1:0]     m_offset_y,
    output logic [HEAD_OUT_W-1:0]       m_heading,
    output logic                        m_sign_undefined
);

    localparam int MW   = CB + 3;
    localparam int DW   = (CB > 12 ? CB : 12) + 3;
    localparam int CW   = MW + 19;
    localparam int PW   = MW + DW;
    localparam int NUMW = PW + 1;
    localparam int UW   = 2*MW + 1;
    localparam int NW   = NUMW + 39;
    localparam int HW   = NW - 23;
    localparam int CNTW = $clog2(STAGES + 1);

    localparam logic signed [ANG_W:0] H6_MAX = 26'sd5760;
    localparam logic signed [ANG_W:0] H6_MIN = -26'sd5760;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_SUM  = 9'b000000100,
        S_NORM = 9'b000001000,
        S_SQRT = 9'b000010000,
        S_DSET = 9'b000100000,
        S_DIV0 = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // unpack request
    logic signed [MW-1:0] h_mx, h_my;
    logic signed [DW-1:0] h_dx, h_dy;
    logic                 h_flag, h_flip;

    assign h_dy   = head_data[DW-1:0];
    assign h_dx   = head_data[2*DW-1:DW];
    assign h_my   = head_data[2*DW+MW-1:2*DW];
    assign h_mx   = head_data[2*DW+2*MW-1:2*DW+MW];
    assign h_flag = head_data[2*DW+2*MW];
    assign h_flip = head_data[2*DW+2*MW+1];

    assign pop = (state_reg == S_IDLE) && !q_stat.empty;

    // item registers
    logic signed [MW-1:0] ux_reg, uy_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic                 flag_reg, flip_reg, mneg_reg, mzero_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            ux_reg    <= (h_mx == '0) ? '0 : h_mx;
            uy_reg    <= (h_mx == '0) ? MW'(1) : h_my;
            dx_reg    <= h_dx;
            dy_reg    <= h_dy;
            flag_reg  <= h_flag;
            flip_reg  <= h_flip;
            mneg_reg  <= h_mx[MW-1];
            mzero_reg <= (h_mx == '0);
        end
    end

    // heading CORDIC
    logic signed [CW-1:0]    cx_reg, cy_reg, cx_next, cy_next, csx, csy;
    logic signed [CW-1:0]    mx_e, my_e, mx_abs;
    logic signed [ANG_W-1:0] cz_reg, cz_next, ang;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic                    c_run;

    assign mx_e   = CW'(h_mx);
    assign my_e   = CW'(h_my);
    assign mx_abs = h_mx[MW-1] ? -mx_e : mx_e;
    assign c_run  = (cnt_reg != CNTW'(STAGES));
    assign csx    = cy_reg >>> cnt_reg;
    assign csy    = cx_reg >>> cnt_reg;
    assign ang    = ang_tab(5'(cnt_reg));

    always_comb begin
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        cz_next  = cz_reg;
        cnt_next = cnt_reg;
        if (pop) begin
            cx_next  = mx_abs <<< 16;
            cy_next  = (h_mx[MW-1] ? -my_e : my_e) <<< 16;
            cz_next  = '0;
            cnt_next = '0;
        end else if (c_run) begin
            cnt_next = cnt_reg + CNTW'(1);
            if (cy_reg > 0) begin
                cx_next = cx_reg + csx;
                cy_next = cy_reg - csy;
                cz_next = cz_reg + ang;
            end else begin
                cx_next = cx_reg - csx;
                cy_next = cy_reg + csy;
                cz_next = cz_reg - ang;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CNTW'(STAGES);
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
    end

    // offset datapath
    logic signed [PW-1:0]  p_xd_reg, p_yd_reg, p_xy_reg, p_yx_reg;
    logic signed [2*MW-1:0] p_uu_reg, p_vv_reg;
    logic signed [PW:0]    dot, crs;
    logic [NUMW-1:0]       adot, acrs;
    logic [UW-1:0]         u2;
    logic [61:0]           w_reg;
    logic [NW-1:0]         nd_reg, nc_reg;
    logic [61:0]           sq_n_reg, sq_res_reg, bitv;
    logic [62:0]           sq_t;
    logic [4:0]            k_reg, j_reg;
    logic [32:0]           d_reg;
    logic [HW-1:0]         hi_d, hi_c;
    logic [32:0]           rem_d_reg, rem_c_reg;
    logic [22:0]           nlo_d_reg, nlo_c_reg, q_d_reg, q_c_reg;
    logic                  sat_d_reg, sat_c_reg;
    logic [33:0]           t_d, t_c;

    assign dot  = PW'(p_xd_reg) + PW'(p_yd_reg);
    assign crs  = (PW+1)'(p_xy_reg) - (PW+1)'(p_yx_reg);
    assign adot = dot[PW] ? NUMW'(-dot) : NUMW'(dot);
    assign acrs = crs[PW] ? NUMW'(-crs) : NUMW'(crs);
    assign u2   = UW'($unsigned(p_uu_reg)) + UW'($unsigned(p_vv_reg));
    assign bitv = 62'(1) << {k_reg, 1'b0};
    assign sq_t = 63'(sq_res_reg) + 63'(bitv);
    assign hi_d = nd_reg[NW-1:23];
    assign hi_c = nc_reg[NW-1:23];
    assign t_d  = {rem_d_reg, nlo_d_reg[22]};
    assign t_c  = {rem_c_reg, nlo_c_reg[22]};

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_MUL: begin
                p_xd_reg <= PW'(ux_reg) * PW'(dx_reg);
                p_yd_reg <= PW'(uy_reg) * PW'(dy_reg);
                p_xy_reg <= PW'(ux_reg) * PW'(dy_reg);
                p_yx_reg <= PW'(uy_reg) * PW'(dx_reg);
                p_uu_reg <= (2*MW)'(ux_reg) * (2*MW)'(ux_reg);
                p_vv_reg <= (2*MW)'(uy_reg) * (2*MW)'(uy_reg);
            end
            S_SUM: begin
                w_reg  <= 62'(u2);
                nd_reg <= NW'(adot) << 9;
                nc_reg <= NW'(acrs) << 9;
            end
            S_NORM: begin
                if (w_reg[61:60] != 2'b00) begin
                    sq_n_reg   <= w_reg;
                    sq_res_reg <= '0;
                    k_reg      <= 5'd30;
                end else if (w_reg[61:54] == 8'd0) begin
                    w_reg  <= w_reg << 8;
                    nd_reg <= nd_reg << 4;
                    nc_reg <= nc_reg << 4;
                end else begin
                    w_reg  <= w_reg << 2;
                    nd_reg <= nd_reg << 1;
                    nc_reg <= nc_reg << 1;
                end
            end
            S_SQRT: begin
                if (63'(sq_n_reg) >= sq_t) begin
                    sq_n_reg   <= 62'(63'(sq_n_reg) - sq_t);
                    sq_res_reg <= (sq_res_reg >> 1) + bitv;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                k_reg <= k_reg - 5'd1;
            end
            S_DSET: begin
                d_reg <= 33'(sq_res_reg[30:0]) + 33'({sq_res_reg[30:0], 1'b0});
            end
            S_DIV0: begin
                sat_d_reg <= (hi_d >= HW'(d_reg));
                sat_c_reg <= (hi_c >= HW'(d_reg));
                rem_d_reg <= (hi_d >= HW'(d_reg)) ? '0 : hi_d[32:0];
                rem_c_reg <= (hi_c >= HW'(d_reg)) ? '0 : hi_c[32:0];
                nlo_d_reg <= nd_reg[22:0];
                nlo_c_reg <= nc_reg[22:0];
                q_d_reg   <= '0;
                q_c_reg   <= '0;
                j_reg     <= '0;
            end
            S_DIV: begin
                if (t_d >= {1'b0, d_reg}) begin
                    rem_d_reg <= 33'(t_d - {1'b0, d_reg});
                    q_d_reg   <= {q_d_reg[21:0], 1'b1};
                end else begin
                    rem_d_reg <= t_d[32:0];
                    q_d_reg   <= {q_d_reg[21:0], 1'b0};
                end
                if (t_c >= {1'b0, d_reg}) begin
                    rem_c_reg <= 33'(t_c - {1'b0, d_reg});
                    q_c_reg   <= {q_c_reg[21:0], 1'b1};
                end else begin
                    rem_c_reg <= t_c[32:0];
                    q_c_reg   <= {q_c_reg[21:0], 1'b0};
                end
                nlo_d_reg <= nlo_d_reg << 1;
                nlo_c_reg <= nlo_c_reg << 1;
                j_reg     <= j_reg + 5'd1;
            end
            default: begin
            end
        endcase
    end

    // result assembly
    logic                    m_valid_reg, m_valid_next;
    logic signed [OFS_W-1:0] m_ox_reg, m_oy_reg;
    logic [HEAD_OUT_W-1:0]   m_head_reg;
    logic                    m_flag_reg;
    logic                    out_free, done_go;
    logic [OFS_W-1:0]        mag_y, mag_x;
    logic [23:0]             q_d1, q_c1;
    logic signed [OFS_W-1:0] ofs_x, ofs_y;
    logic signed [ANG_W:0]   zs, h6, h6c;
    logic [HEAD_W-1:0]       head_a, head_b, head_c;
    logic                    dy_pos;

    assign out_free = !m_valid_reg || m_ready;
    assign done_go  = (state_reg == S_DONE) && !c_run && out_free;

    assign q_d1  = 24'(q_d_reg) + 24'd1;
    assign q_c1  = 24'(q_c_reg) + 24'd1;
    assign mag_y = (sat_d_reg || q_d_reg >= 23'h3F_FFFF) ? OFS_MAX : q_d1[OFS_W:1];
    assign mag_x = (sat_c_reg || q_c_reg >= 23'h3F_FFFF) ? OFS_MAX : q_c1[OFS_W:1];
    assign dy_pos = !dy_reg[DW-1] && (dy_reg != '0);

    always_comb begin
        if (flag_reg) begin
            ofs_x = '0;
            ofs_y = '0;
        end else if (dy_pos) begin
            ofs_x = -$signed(mag_x);
            ofs_y = -$signed(mag_y);
        end else begin
            ofs_x = $signed(mag_x);
            ofs_y = $signed(mag_y);
        end
    end

    assign zs = (ANG_W+1)'(cz_reg) + (ANG_W+1)'(512);
    assign h6 = zs >>> 10;

    always_comb begin
        if (h6 > H6_MAX) begin
            h6c = H6_MAX;
        end else if (h6 < H6_MIN) begin
            h6c = H6_MIN;
        end else begin
            h6c = h6;
        end
        if (mzero_reg) begin
            head_a = '0;
        end else begin
            head_a = HEAD_W'(h6c) + HEAD_QUARTER + (mneg_reg ? HEAD_HALF : '0);
        end
        head_b = head_a + (flip_reg ? HEAD_HALF : '0);
        head_c = (head_b > HEAD_FULL) ? head_b - HEAD_FULL : head_b;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (pop) state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_NORM;
            S_NORM: if (w_reg[61:60] != 2'b00) state_next = S_SQRT;
            S_SQRT: if (k_reg == 5'd0) state_next = S_DSET;
            S_DSET: state_next = S_DIV0;
            S_DIV0: state_next = S_DIV;
            S_DIV:  if (j_reg == 5'd22) state_next = S_DONE;
            S_DONE: if (done_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (done_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_go) begin
            m_ox_reg   <= ofs_x;
            m_oy_reg   <= ofs_y;
            m_head_reg <= HEAD_OUT_W'(head_c);
            m_flag_reg <= flag_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_offset_x       = m_ox_reg;
    assign m_offset_y       = m_oy_reg;
    assign m_heading        = m_head_reg;
    assign m_sign_undefined = m_flag_reg;

endmodule
